### design/glrc_pkg.sv
package glrc_pkg;

    localparam int MAP_COLS       = 512;
    localparam int MAP_ROWS       = 512;
    localparam int TRIG_FRAC_BITS = 15;

    localparam int CELLS   = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int POS_W   = 14;
    localparam int MAG_W   = TRIG_FRAC_BITS + 1;
    localparam int ACC_W   = MAG_W + 10;
    localparam int RANGE_W = 28;
    localparam int CFG_W   = 16;

    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [10:0] STEP_LIMIT = 11'd1024;

    typedef enum logic [2:0] {
        CFG_COLS  = 3'd0,
        CFG_ROWS  = 3'd1,
        CFG_NEG   = 3'd2,
        CFG_LEVEL = 3'd3,
        CFG_STEPS = 3'd4,
        CFG_CELL  = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T,
        ST_T2,
        ST_P,
        ST_DIV,
        ST_S,
        ST_MA,
        ST_MC,
        ST_RANGE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        action;
        logic [8:0]  pos_col;
        logic [8:0]  pos_row;
        logic [7:0]  gray_level;
        logic [15:0] beam_angle;
    } in_item_t;

    typedef struct packed {
        logic               hit_found;
        logic [10:0]        hit_step;
        logic signed [27:0] range_q16;
    } out_item_t;

endpackage

### design/grid_laser_ray_cast.sv
// write transaction: writes the map cell, no result
// ray transaction: sine and cosine set-up on the shared multiplier, then the march
// (one map read per marched step), the range, and loading the result
// one item at a time; ready only while the sequencer is idle, a waiting result holds it
// synchronous active-low reset clears control and configuration, not the map contents
module grid_laser_ray_cast import glrc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [9:0]  cols_cfg_reg, rows_cfg_reg;
    logic        neg_cfg_reg;
    logic [7:0]  level_cfg_reg;
    logic [10:0] steps_cfg_reg;
    logic [15:0] cell_cfg_reg;

    logic        wait_reg, wait_next;
    logic        first_reg, first_next;
    logic [15:0] angle_reg, angle_next;
    logic [14:0] r_reg, r_next;
    logic        neg_reg, neg_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] t2_reg, t2_next;
    logic [30:0] u_reg, u_next;
    logic [30:0] x_reg, x_next;
    logic [2:0]  iter_reg, iter_next;
    logic [MAG_W-1:0] cmag_reg, cmag_next, smag_reg, smag_next;
    logic        cneg_reg, cneg_next, sneg_reg, sneg_next;
    logic [8:0]  col_reg, col_next, row_reg, row_next;
    logic [10:0] k_reg, k_next;
    logic [ACC_W-1:0] accc_reg, accc_next, accs_reg, accs_next;
    logic        hit_reg, hit_next;
    logic [RANGE_W-1:0] range_reg, range_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   out_reg, out_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [30:0] div_scaled;
    logic [31:0] div_magic;
    logic [30:0] quotient;
    logic        mem_we, mem_wd, mem_rd;
    logic [ADDR_W-1:0] mem_addr;

    logic [POS_W-1:0] cols_eff, rows_eff;
    logic [10:0]      steps_eff;
    logic [7:0]       dark;
    logic [15:0]      cos_angle;
    logic [10:0]      offc, offs;
    logic signed [POS_W-1:0] pu, pv;
    logic             oob;
    logic [32:0]      rnd_sum;
    logic [MAG_W-1:0] mag;
    logic [RANGE_W-1:0] rng_sum;

    glrc_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    glrc_div u_div (
        .sel      (iter_reg),
        .dividend (prod[61:30]),
        .prod     (prod),
        .scaled   (div_scaled),
        .magic    (div_magic),
        .quotient (quotient)
    );

    glrc_map u_map (
        .aclk (aclk),
        .we   (mem_we),
        .addr (mem_addr),
        .wd   (mem_wd),
        .rd_q (mem_rd)
    );

    assign cols_eff = (POS_W'(cols_cfg_reg) > POS_W'(MAP_COLS)) ? POS_W'(MAP_COLS)
                                                                : POS_W'(cols_cfg_reg);
    assign rows_eff = (POS_W'(rows_cfg_reg) > POS_W'(MAP_ROWS)) ? POS_W'(MAP_ROWS)
                                                                : POS_W'(rows_cfg_reg);
    assign steps_eff = (steps_cfg_reg > STEP_LIMIT) ? STEP_LIMIT : steps_cfg_reg;
    assign dark      = neg_cfg_reg ? s_item.gray_level : 8'd255 - s_item.gray_level;
    assign cos_angle = s_item.beam_angle + 16'd16384;

    assign offc = accc_reg[ACC_W-1:TRIG_FRAC_BITS];
    assign offs = accs_reg[ACC_W-1:TRIG_FRAC_BITS];
    assign pu = cneg_reg ? $signed(POS_W'(col_reg)) - $signed(POS_W'(offc))
                         : $signed(POS_W'(col_reg)) + $signed(POS_W'(offc));
    assign pv = sneg_reg ? $signed(POS_W'(row_reg)) + $signed(POS_W'(offs))
                         : $signed(POS_W'(row_reg)) - $signed(POS_W'(offs));
    assign oob = pu[POS_W-1] || pv[POS_W-1] || (POS_W'(pu) >= cols_eff)
              || (POS_W'(pv) >= rows_eff);

    // round the Q30 sine to the trig format
    assign rnd_sum = 33'(prod[61:30]) + (33'd1 << (29 - TRIG_FRAC_BITS));
    assign mag     = MAG_W'(rnd_sum >> (30 - TRIG_FRAC_BITS));
    assign rng_sum = RANGE_W'(prod[RANGE_W-2:0]) + RANGE_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            cols_cfg_reg  <= 10'd512;
            rows_cfg_reg  <= 10'd512;
            neg_cfg_reg   <= 1'b0;
            level_cfg_reg <= 8'd166;
            steps_cfg_reg <= 11'd512;
            cell_cfg_reg  <= 16'd3277;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_COLS:  cols_cfg_reg  <= cfg_data[9:0];
                    CFG_ROWS:  rows_cfg_reg  <= cfg_data[9:0];
                    CFG_NEG:   neg_cfg_reg   <= cfg_data[0];
                    CFG_LEVEL: level_cfg_reg <= cfg_data[7:0];
                    CFG_STEPS: steps_cfg_reg <= cfg_data[10:0];
                    CFG_CELL:  cell_cfg_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        angle_reg <= angle_next;
        r_reg     <= r_next;
        neg_reg   <= neg_next;
        t_reg     <= t_next;
        t2_reg    <= t2_next;
        u_reg     <= u_next;
        x_reg     <= x_next;
        iter_reg  <= iter_next;
        cmag_reg  <= cmag_next;
        smag_reg  <= smag_next;
        cneg_reg  <= cneg_next;
        sneg_reg  <= sneg_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        k_reg     <= k_next;
        accc_reg  <= accc_next;
        accs_reg  <= accs_next;
        hit_reg   <= hit_next;
        range_reg <= range_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        wait_next    = wait_reg;
        first_next   = first_reg;
        angle_next   = angle_reg;
        r_next       = r_reg;
        neg_next     = neg_reg;
        t_next       = t_reg;
        t2_next      = t2_reg;
        u_next       = u_reg;
        x_next       = x_reg;
        iter_next    = iter_reg;
        cmag_next    = cmag_reg;
        smag_next    = smag_reg;
        cneg_next    = cneg_reg;
        sneg_next    = sneg_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        k_next       = k_reg;
        accc_next    = accc_reg;
        accs_next    = accs_reg;
        hit_next     = hit_reg;
        range_next   = range_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        mul_a        = '0;
        mul_b        = '0;
        mem_we       = 1'b0;
        mem_wd       = dark > level_cfg_reg;
        mem_addr     = ADDR_W'(pv) * ADDR_W'(MAP_COLS) + ADDR_W'(pu);
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                mem_addr = ADDR_W'(s_item.pos_row) * ADDR_W'(MAP_COLS)
                         + ADDR_W'(s_item.pos_col);
                if (s_valid) begin
                    if (!s_item.action) begin
                        mem_we = (POS_W'(s_item.pos_col) < cols_eff)
                              && (POS_W'(s_item.pos_row) < rows_eff);
                    end else begin
                        angle_next = s_item.beam_angle;
                        col_next   = s_item.pos_col;
                        row_next   = s_item.pos_row;
                        first_next = 1'b1;
                        neg_next   = cos_angle[15];
                        r_next     = cos_angle[14] ? 15'd16384 - 15'(cos_angle[13:0])
                                                   : 15'(cos_angle[13:0]);
                        wait_next  = 1'b0;
                        state_next = ST_T;
                    end
                end
            end
            ST_T: begin
                mul_a     = 32'(r_reg);
                mul_b     = PI_Q30;
                wait_next = !wait_reg;
                if (wait_reg) begin
                    t_next     = prod[46:15];
                    state_next = ST_T2;
                end
            end
            ST_T2: begin
                mul_a     = t_reg;
                mul_b     = t_reg;
                wait_next = !wait_reg;
                if (wait_reg) begin
                    t2_next    = prod[61:30];
                    u_next     = ONE_Q30;
                    iter_next  = '0;
                    state_next = ST_P;
                end
            end
            ST_P: begin
                mul_a     = t2_reg;
                mul_b     = 32'(u_reg);
                wait_next = !wait_reg;
                if (wait_reg) begin
                    x_next     = div_scaled;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                mul_a     = 32'(x_reg);
                mul_b     = div_magic;
                wait_next = !wait_reg;
                if (wait_reg) begin
                    u_next     = ONE_Q30 - quotient;
                    iter_next  = iter_reg + 3'd1;
                    state_next = (iter_reg == 3'd4) ? ST_S : ST_P;
                end
            end
            ST_S: begin
                mul_a     = t_reg;
                mul_b     = 32'(u_reg);
                wait_next = !wait_reg;
                if (wait_reg) begin
                    if (first_reg) begin
                        cmag_next  = mag;
                        cneg_next  = neg_reg;
                        first_next = 1'b0;
                        neg_next   = angle_reg[15];
                        r_next     = angle_reg[14] ? 15'd16384 - 15'(angle_reg[13:0])
                                                   : 15'(angle_reg[13:0]);
                        state_next = ST_T;
                    end else begin
                        smag_next  = mag;
                        sneg_next  = neg_reg;
                        k_next     = '0;
                        accc_next  = '0;
                        accs_next  = '0;
                        state_next = ST_MA;
                    end
                end
            end
            ST_MA: begin
                if (k_reg >= steps_eff || oob) begin
                    hit_next   = 1'b0;
                    range_next = '0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MC;
                end
            end
            ST_MC: begin
                if (mem_rd) begin
                    hit_next   = 1'b1;
                    wait_next  = 1'b0;
                    state_next = ST_RANGE;
                end else begin
                    k_next     = k_reg + 11'd1;
                    accc_next  = accc_reg + ACC_W'(cmag_reg);
                    accs_next  = accs_reg + ACC_W'(smag_reg);
                    state_next = ST_MA;
                end
            end
            ST_RANGE: begin
                // hit on the origin cell gives minus half a cell
                if (k_reg == 11'd0) begin
                    range_next = RANGE_W'(0) - RANGE_W'(cell_cfg_reg >> 1);
                    state_next = ST_DONE;
                end else begin
                    mul_a     = 32'({k_reg, 1'b0} - 12'd1);
                    mul_b     = 32'(cell_cfg_reg);
                    wait_next = !wait_reg;
                    if (wait_reg) begin
                        range_next = rng_sum >> 1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.hit_found = hit_reg;
                    out_next.hit_step  = hit_reg ? k_reg : 11'd0;
                    out_next.range_q16 = range_reg;
                    m_valid_next       = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

### design/glrc_mul.sv
module glrc_mul import glrc_pkg::*; (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule

### design/glrc_div.sv
module glrc_div import glrc_pkg::*; (
    input  logic [2:0]  sel,
    input  logic [31:0] dividend,
    input  logic [63:0] prod,
    output logic [30:0] scaled,
    output logic [31:0] magic,
    output logic [30:0] quotient
);

    logic [2:0]  pre_sh;
    logic [5:0]  post_sh;
    logic [63:0] q_full;

    // series divisors 110, 72, 42, 20, 6: power-of-two factor shifted out,
    // odd factor by reciprocal multiply, exact for a 31-bit scaled dividend
    always_comb begin
        case (sel)
            3'd0: begin
                pre_sh  = 3'd1;
                magic   = 32'd2498890064;
                post_sh = 6'd37;
            end
            3'd1: begin
                pre_sh  = 3'd3;
                magic   = 32'd3817748708;
                post_sh = 6'd35;
            end
            3'd2: begin
                pre_sh  = 3'd1;
                magic   = 32'd3272356036;
                post_sh = 6'd36;
            end
            3'd3: begin
                pre_sh  = 3'd2;
                magic   = 32'd3435973837;
                post_sh = 6'd34;
            end
            default: begin
                pre_sh  = 3'd1;
                magic   = 32'd2863311531;
                post_sh = 6'd33;
            end
        endcase
    end

    assign scaled   = 31'(dividend >> pre_sh);
    assign q_full   = prod >> post_sh;
    assign quotient = q_full[30:0];

endmodule

### design/glrc_map.sv
module glrc_map import glrc_pkg::*; (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic              wd,
    output logic              rd_q
);

    logic mem [CELLS];
    logic rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wd;
        end
        rd_reg <= mem[addr];
    end

    assign rd_q = rd_reg;

endmodule
